### sv/extent_filter_dedup_assert.svh
// ---------------------------------------------------------------------------
// extent_filter_dedup assertion macros
// shared property shorthands for the port-level checker
// ---------------------------------------------------------------------------
`ifndef EXTENT_FILTER_DEDUP_ASSERT_SVH
`define EXTENT_FILTER_DEDUP_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define EFD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("extent_filter_dedup check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define EFD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("extent_filter_dedup check failed");

`endif

### sv/efd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_pkg
// shared widths, codes and types of the extent filter and dedup block
// ---------------------------------------------------------------------------
package efd_pkg;

    localparam int LOG_W   = 32;
    localparam int LEN_W   = 16;
    localparam int PHYS_W  = 48;
    localparam int KEY_W   = LOG_W + LEN_W;
    localparam int DEV_W   = 49;
    localparam int UCNT_W  = 7;

    typedef enum logic [2:0] {
        REASON_KEPT   = 3'd0,
        REASON_ZERO   = 3'd1,
        REASON_BEYOND = 3'd2,
        REASON_DUP    = 3'd3,
        REASON_FULL   = 3'd4
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE
    } state_t;

    // one table entry, also used as the probe word
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PHYS_W-1:0] phys;
    } entry_t;

endpackage

### sv/efd_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_cell
// one table entry: takes its neighbor's entry on insert, compares to probe
// ---------------------------------------------------------------------------
module efd_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  efd_pkg::entry_t shift_in,
    input  efd_pkg::entry_t probe,
    input  logic            live,
    output efd_pkg::entry_t entry,
    output logic            match
);
    import efd_pkg::*;

    entry_t entry_reg;
    logic   match_reg;

    // entry payload, no reset: unused until the fill count covers it
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= live && (entry_reg == probe);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

### sv/efd_chain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_chain
// row of entry cells, insert at the head, or-reduce of the match bits
// ---------------------------------------------------------------------------
module efd_chain #(
    parameter  int MAX_EXTENTS = 64,
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  efd_pkg::entry_t  probe,
    input  logic [CNT_W-1:0] kept_total,
    output logic             any_match
);
    import efd_pkg::*;

    entry_t                 entries [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] match_vec;

    for (genvar k = 0; k < MAX_EXTENTS; k++)
    begin : g_cell
        entry_t cell_in;
        logic   cell_live;

        // new entry enters cell 0, the rest move one place down
        if (k == 0)
        begin : g_head
            assign cell_in = probe;
        end
        else
        begin : g_body
            assign cell_in = entries[k-1];
        end

        // cells below the fill count hold entries of the current set
        assign cell_live = CNT_W'(k) < kept_total;

        efd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .shift_in (cell_in),
            .probe    (probe),
            .live     (cell_live),
            .entry    (entries[k]),
            .match    (match_vec[k])
        );
    end

    assign any_match = |match_vec;

endmodule

### sv/extent_filter_dedup.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// extent_filter_dedup
// streaming filter and de-duplicator for filesystem extents
// ---------------------------------------------------------------------------
// An extent word is taken when start is high and busy is low. Each word goes
// through a compare cycle, in which every table cell compares its entry
// against the word and registers a match bit, then a decision cycle, in which
// the match bits are or-ed, the drop reason is chosen and a kept extent is
// pushed into the head of the cell row. busy is high only in the compare cycle,
// so a new word may be started in the decision cycle of the one before. The
// registered result is on the output ports for exactly one cycle, marked by
// done; the receiver cannot stall it, so it must sample whenever done is high.
// Every word gives exactly one result. The device size must be written through
// cfg_we / cfg_wdata only while no word is in flight; the block does not
// enforce this. The table is cleared by resetting its fill count after the word
// marked last_of_set, so there is no clearing pass after reset.
// ---------------------------------------------------------------------------
module extent_filter_dedup #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command side
    input  logic                       start,
    output logic                       busy,
    input  logic [efd_pkg::LOG_W-1:0]  logical_block,
    input  logic [efd_pkg::LEN_W-1:0]  extent_length,
    input  logic [efd_pkg::PHYS_W-1:0] physical_start,
    input  logic                       last_of_set,
    // device size register
    input  logic                       cfg_we,
    input  logic [efd_pkg::DEV_W-1:0]  cfg_wdata,
    // result side
    output logic                       done,
    output logic                       keep,
    output logic [2:0]                 drop_reason,
    output logic [efd_pkg::LOG_W-1:0]  kept_logical,
    output logic [efd_pkg::LEN_W-1:0]  kept_length,
    output logic [efd_pkg::PHYS_W-1:0] kept_start,
    output logic [efd_pkg::UCNT_W-1:0] set_count,
    output logic                       set_done
);
    import efd_pkg::*;

    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

    // control
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   kept_total_reg, kept_total_next;
    logic [DEV_W-1:0]   dev_size_reg;
    logic               done_reg;

    // word being worked on
    logic [LOG_W-1:0]   logical_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [PHYS_W-1:0]  start_reg;
    logic               last_reg;

    // early checks, registered in the compare cycle
    logic               zero_reg;
    logic               beyond_reg;

    // result registers
    logic               keep_reg;
    reason_t            reason_reg;
    logic [LOG_W-1:0]   res_logical_reg;
    logic [LEN_W-1:0]   res_length_reg;
    logic [PHYS_W-1:0]  res_start_reg;
    logic [UCNT_W-1:0]  res_count_reg;
    logic               res_last_reg;

    logic               accept;
    logic               decide;
    logic               any_match;
    logic               table_full;
    logic [DEV_W-1:0]   extent_end;
    reason_t            reason;
    logic               kept;
    logic [CNT_W-1:0]   count_after;
    entry_t             probe;

    assign accept = start && !busy;
    assign decide = (state_reg == ST_DECIDE);

    assign probe.key  = {logical_reg, length_reg};
    assign probe.phys = start_reg;

    // ---------------------------------------------------------------------
    // state machine
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                // cells are comparing against the held word
                busy       = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // the held word is used up this cycle, so a new one may come
                state_next = start ? ST_MATCH : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // word capture and early checks
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            logical_reg <= logical_block;
            length_reg  <= extent_length;
            start_reg   <= physical_start;
            last_reg    <= last_of_set;
        end
    end

    // end of the extent cannot carry out of 49 bits
    assign extent_end = {1'b0, start_reg} + {{(DEV_W - LEN_W){1'b0}}, length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg   <= 1'b0;
            beyond_reg <= 1'b0;
        end
        else
        begin
            zero_reg   <= (length_reg == '0) || (start_reg == '0);
            beyond_reg <= extent_end > dev_size_reg;
        end
    end

    // ---------------------------------------------------------------------
    // device size register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            dev_size_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // table of kept extents
    // ---------------------------------------------------------------------
    efd_chain #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (decide && kept),
        .probe      (probe),
        .kept_total (kept_total_reg),
        .any_match  (any_match)
    );

    // ---------------------------------------------------------------------
    // decision: zero, then device bound, then duplicate, then full
    // ---------------------------------------------------------------------
    assign table_full = (kept_total_reg == CNT_W'(MAX_EXTENTS));

    always_comb
    begin
        if (zero_reg)
        begin
            reason = REASON_ZERO;
        end
        else if (beyond_reg)
        begin
            reason = REASON_BEYOND;
        end
        else if (any_match)
        begin
            reason = REASON_DUP;
        end
        else if (table_full)
        begin
            reason = REASON_FULL;
        end
        else
        begin
            reason = REASON_KEPT;
        end
    end

    assign kept        = (reason == REASON_KEPT);
    assign count_after = kept ? kept_total_reg + CNT_W'(1) : kept_total_reg;

    // the set's count goes back to zero after its last word
    always_comb
    begin
        kept_total_next = kept_total_reg;
        if (decide)
        begin
            kept_total_next = last_reg ? '0 : count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            kept_total_reg <= kept_total_next;
            done_reg       <= decide;
        end
    end

    // result payload, shown for the one cycle that done is high
    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            keep_reg        <= kept;
            reason_reg      <= reason;
            res_logical_reg <= logical_reg;
            res_length_reg  <= length_reg;
            res_start_reg   <= start_reg;
            res_count_reg   <= UCNT_W'(count_after);
            res_last_reg    <= last_reg;
        end
    end

    assign done         = done_reg;
    assign keep         = keep_reg;
    assign drop_reason  = reason_reg;
    assign kept_logical = res_logical_reg;
    assign kept_length  = res_length_reg;
    assign kept_start   = res_start_reg;
    assign set_count    = res_count_reg;
    assign set_done     = res_last_reg;

endmodule

### sv/efd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// efd_checker
// port-level checks of the extent filter and dedup block
// ---------------------------------------------------------------------------
`include "extent_filter_dedup_assert.svh"

module efd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       keep,
    input logic [2:0]                 drop_reason,
    input logic [efd_pkg::LEN_W-1:0]  kept_length,
    input logic [efd_pkg::PHYS_W-1:0] kept_start
);
    import efd_pkg::*;

    logic zero_field;

    assign zero_field = (kept_length == '0) || (kept_start == '0);

    // a taken word holds the command side for its compare cycle
    `EFD_ASSERT_NXT(a_busy_after_start, start && !busy, busy)

    // every taken word gives its result, marked by done
    `EFD_ASSERT_IMP(a_result_latency, start && !busy, ##3 done)

    // a new word is taken no earlier than the decision cycle of the last, so results never run back to back
    `EFD_ASSERT_NXT(a_done_isolated, done, !done)

    // keep agrees with the reason code
    `EFD_ASSERT_IMP(a_keep_reason, done, keep == (drop_reason == REASON_KEPT))

    // a zero drop really had a zero field
    `EFD_ASSERT_IMP(a_zero_reason, done && drop_reason == REASON_ZERO, zero_field)

endmodule

bind extent_filter_dedup efd_checker u_efd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .keep        (keep),
    .drop_reason (drop_reason),
    .kept_length (kept_length),
    .kept_start  (kept_start)
);
